[src/chained_hash_table_engine_assert.svh]
// Assertion macros shared by the hash table engine RTL.
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define CHT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on every edge, reset included
`define CHT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CHT_ASSERT(name, prop, msg)
`define CHT_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

[src/cht_pkg.sv]
// Constants, codes and types of the hash table engine.
package cht_pkg;
    localparam int MAX_BUCKETS = 1024;
    localparam int POOL_NODES  = 1024;
    localparam int MIN_BUCKETS = 16;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = $clog2(POOL_NODES);
    localparam int LINK_W = IDX_W + 1;
    localparam int BKT_W  = $clog2(MAX_BUCKETS);
    localparam int NODE_W = KEY_W + PAY_W + LINK_W;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);

    typedef enum logic [1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_DUP  = 2'd2;
    localparam logic [1:0] STAT_FULL = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_WT,
        S_NODE_WT,
        S_POP_WT,
        S_LINK_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } mod_rsp_t;
endpackage

[src/cht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[src/cht_mod.sv]
// Key modulo bucket count, four quotient bits per cycle.
module cht_mod (
    input  logic              aclk,
    input  logic              aresetn,
    input  cht_pkg::mod_req_t req,
    output cht_pkg::mod_rsp_t rsp
);
    localparam int DIGIT = 4;
    localparam int ITER  = cht_pkg::KEY_W / DIGIT;
    localparam int CW    = $clog2(ITER);

    logic [cht_pkg::KEY_W-1:0] dvd_reg, dvd_next;
    logic [cht_pkg::CFG_W-1:0] rem_reg, rem_next;
    logic [cht_pkg::CFG_W-1:0] div_reg, div_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    always_comb begin
        logic [cht_pkg::CFG_W:0]   r;
        logic [cht_pkg::KEY_W-1:0] d;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r = {1'b0, rem_reg};
        d = dvd_reg;
        if (req.start) begin
            dvd_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int i = 0; i < DIGIT; i++) begin
                r = {r[cht_pkg::CFG_W-1:0], d[cht_pkg::KEY_W-1]};
                d = {d[cht_pkg::KEY_W-2:0], 1'b0};
                if (r >= {1'b0, div_reg}) begin
                    r = r - {1'b0, div_reg};
                end
            end
            dvd_next = d;
            rem_next = r[cht_pkg::CFG_W-1:0];
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(ITER - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
endmodule

[src/chained_hash_table_engine.sv]
// Hash table of 32-bit keys with separate chaining: one request word in, one
// result word out. After reset a clearing pass empties the 1024 bucket heads,
// one per cycle, and no request is taken until that pass ends. A request then
// goes through the key modulo in the four-bit-per-step remainder unit, the
// bucket head read, one read per chain node visited from the node memory, the
// result hand-off and the return to idle, and for an insert the pop write and,
// behind a node, the link write. One request is in work at a time; a finished
// result waits in the output register while the next request is taken. The user
// must write bucket_count only while no request is in work; the block itself
// does not enforce it.
module chained_hash_table_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], payload_in[63:32]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // payload_out[31:0], entry_index[41:32], zero
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);
`include "chained_hash_table_engine_assert.svh"

    localparam int LW = cht_pkg::LINK_W;
    localparam int IW = cht_pkg::IDX_W;
    localparam int BW = cht_pkg::BKT_W;
    localparam int KW = cht_pkg::KEY_W;
    localparam int PW = cht_pkg::PAY_W;

    cht_pkg::state_t state_reg, state_next;

    logic [cht_pkg::CFG_W-1:0] bcount_reg, bcount_next;
    logic [1:0]      op_reg, op_next;
    logic [KW-1:0]   key_reg, key_next;
    logic [PW-1:0]   pay_reg, pay_next;
    logic [BW-1:0]   bkt_reg, bkt_next;
    logic [LW-1:0]   cur_reg, cur_next;
    logic [LW-1:0]   prev_reg, prev_next;
    logic [KW-1:0]   pkey_reg, pkey_next;
    logic [PW-1:0]   ppay_reg, ppay_next;
    logic [IW-1:0]   nidx_reg, nidx_next;
    logic [LW-1:0]   fcnt_reg, fcnt_next;
    logic [LW-1:0]   low_reg, low_next;
    logic [BW-1:0]   clr_reg, clr_next;
    logic [1:0]      rst_reg, rst_next;
    logic [PW-1:0]   rpay_reg, rpay_next;
    logic [IW-1:0]   ridx_reg, ridx_next;
    logic            mval_reg, mval_next;
    logic [1:0]      mst_reg, mst_next;
    logic [PW-1:0]   mpay_reg, mpay_next;
    logic [IW-1:0]   midx_reg, midx_next;

    logic              head_we, head_re;
    logic [BW-1:0]     head_waddr;
    logic [LW-1:0]     head_wdata, head_rdata;
    logic              node_we, node_re;
    logic [IW-1:0]     node_waddr, node_raddr;
    logic [cht_pkg::NODE_W-1:0] node_wdata, node_rdata;
    logic              free_we, free_re;
    logic [IW-1:0]     free_waddr, free_raddr, free_rdata;

    cht_pkg::mod_req_t mod_req;
    cht_pkg::mod_rsp_t mod_rsp;

    logic [KW-1:0] nkey;
    logic [PW-1:0] npay;
    logic [LW-1:0] nlink;
    logic [LW-1:0] fcnt_dec;
    logic [IW-1:0] pop_idx;
    logic          s_acc;

    assign nkey     = node_rdata[cht_pkg::NODE_W-1 -: KW];
    assign npay     = node_rdata[LW +: PW];
    assign nlink    = node_rdata[LW-1:0];
    assign fcnt_dec = fcnt_reg - LW'(1);
    // below the low-water mark the stack still holds its initial contents
    assign pop_idx  = (fcnt_reg == low_reg) ? IW'(LW'(cht_pkg::POOL_NODES) - fcnt_reg)
                                            : free_rdata;
    assign s_acc    = s_tvalid && s_tready;

    cht_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    cht_ram #(.WIDTH(LW), .DEPTH(cht_pkg::MAX_BUCKETS)) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (bkt_reg),
        .rdata (head_rdata)
    );

    cht_ram #(.WIDTH(cht_pkg::NODE_W), .DEPTH(cht_pkg::POOL_NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    cht_ram #(.WIDTH(IW), .DEPTH(cht_pkg::POOL_NODES)) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (cur_reg[IW-1:0]),
        .re    (free_re),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cht_pkg::S_CLEAR: begin
                if (clr_reg == BW'(cht_pkg::MAX_BUCKETS - 1)) begin
                    state_next = cht_pkg::S_IDLE;
                end
            end
            cht_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == cht_pkg::OP_SEARCH || s_tuser == cht_pkg::OP_INSERT ||
                        s_tuser == cht_pkg::OP_REMOVE) begin
                        state_next = cht_pkg::S_MOD;
                    end else begin
                        state_next = cht_pkg::S_RESP;
                    end
                end
            end
            cht_pkg::S_MOD: begin
                if (mod_rsp.done) begin
                    state_next = cht_pkg::S_HEAD_RD;
                end
            end
            cht_pkg::S_HEAD_RD: state_next = cht_pkg::S_HEAD_WT;
            cht_pkg::S_HEAD_WT: begin
                if (head_rdata != cht_pkg::NULL_LINK) begin
                    state_next = cht_pkg::S_NODE_WT;
                end else if (op_reg == cht_pkg::OP_INSERT && fcnt_reg != '0) begin
                    state_next = cht_pkg::S_POP_WT;
                end else begin
                    state_next = cht_pkg::S_RESP;
                end
            end
            cht_pkg::S_NODE_WT: begin
                if (nkey == key_reg) begin
                    state_next = cht_pkg::S_RESP;
                end else if (nlink != cht_pkg::NULL_LINK) begin
                    state_next = cht_pkg::S_NODE_WT;
                end else if (op_reg == cht_pkg::OP_INSERT && fcnt_reg != '0) begin
                    state_next = cht_pkg::S_POP_WT;
                end else begin
                    state_next = cht_pkg::S_RESP;
                end
            end
            cht_pkg::S_POP_WT: begin
                state_next = (prev_reg == cht_pkg::NULL_LINK) ? cht_pkg::S_RESP
                                                              : cht_pkg::S_LINK_WR;
            end
            cht_pkg::S_LINK_WR: state_next = cht_pkg::S_RESP;
            cht_pkg::S_RESP: begin
                if (!mval_reg || m_tready) begin
                    state_next = cht_pkg::S_IDLE;
                end
            end
            default: state_next = cht_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        logic [cht_pkg::CFG_W-1:0] cv;
        cv          = cfg_data;
        bcount_next = bcount_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        bkt_next    = bkt_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        pkey_next   = pkey_reg;
        ppay_next   = ppay_reg;
        nidx_next   = nidx_reg;
        fcnt_next   = fcnt_reg;
        low_next    = low_reg;
        clr_next    = clr_reg;
        rst_next    = rst_reg;
        rpay_next   = rpay_reg;
        ridx_next   = ridx_reg;
        mval_next   = mval_reg;
        mst_next    = mst_reg;
        mpay_next   = mpay_reg;
        midx_next   = midx_reg;
        s_tready    = 1'b0;
        head_we     = 1'b0;
        head_re     = 1'b0;
        head_waddr  = bkt_reg;
        head_wdata  = cht_pkg::NULL_LINK;
        node_we     = 1'b0;
        node_re     = 1'b0;
        node_waddr  = prev_reg[IW-1:0];
        node_wdata  = {pkey_reg, ppay_reg, nlink};
        node_raddr  = nlink[IW-1:0];
        free_we     = 1'b0;
        free_re     = 1'b0;
        free_waddr  = fcnt_reg[IW-1:0];
        free_raddr  = fcnt_dec[IW-1:0];
        mod_req.start    = 1'b0;
        mod_req.dividend = key_reg;
        mod_req.divisor  = bcount_reg;

        if (m_tready) begin
            mval_next = 1'b0;
        end
        if (cfg_valid) begin
            if (cv < cht_pkg::CFG_W'(cht_pkg::MIN_BUCKETS)) begin
                bcount_next = cht_pkg::CFG_W'(cht_pkg::MIN_BUCKETS);
            end else if (cv > cht_pkg::CFG_W'(cht_pkg::MAX_BUCKETS)) begin
                bcount_next = cht_pkg::CFG_W'(cht_pkg::MAX_BUCKETS);
            end else begin
                bcount_next = cv;
            end
        end

        unique case (state_reg)
            cht_pkg::S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + BW'(1);
            end
            cht_pkg::S_IDLE: begin
                s_tready  = 1'b1;
                op_next   = s_tuser;
                key_next  = s_tdata[KW-1:0];
                pay_next  = s_tdata[KW +: PW];
                rst_next  = cht_pkg::STAT_MISS;
                rpay_next = '0;
                ridx_next = '0;
                if (s_acc) begin
                    mod_req.start    = 1'b1;
                    mod_req.dividend = s_tdata[KW-1:0];
                end
            end
            cht_pkg::S_MOD: begin
                bkt_next = mod_rsp.rem[BW-1:0];
            end
            cht_pkg::S_HEAD_RD: begin
                head_re = 1'b1;
            end
            cht_pkg::S_HEAD_WT: begin
                cur_next   = head_rdata;
                prev_next  = cht_pkg::NULL_LINK;
                node_raddr = head_rdata[IW-1:0];
                if (head_rdata != cht_pkg::NULL_LINK) begin
                    node_re = 1'b1;
                end else if (op_reg == cht_pkg::OP_INSERT) begin
                    if (fcnt_reg == '0) begin
                        rst_next = cht_pkg::STAT_FULL;
                    end else begin
                        free_re = 1'b1;
                    end
                end
            end
            cht_pkg::S_NODE_WT: begin
                if (nkey == key_reg) begin
                    unique case (op_reg)
                        cht_pkg::OP_INSERT: rst_next = cht_pkg::STAT_DUP;
                        cht_pkg::OP_REMOVE: begin
                            rst_next  = cht_pkg::STAT_OK;
                            rpay_next = npay;
                            ridx_next = cur_reg[IW-1:0];
                            if (prev_reg == cht_pkg::NULL_LINK) begin
                                head_we    = 1'b1;
                                head_wdata = nlink;
                            end else begin
                                node_we = 1'b1;
                            end
                            if (fcnt_reg < LW'(cht_pkg::POOL_NODES)) begin
                                free_we   = 1'b1;
                                fcnt_next = fcnt_reg + LW'(1);
                            end
                        end
                        default: begin
                            rst_next  = cht_pkg::STAT_OK;
                            rpay_next = npay;
                            ridx_next = cur_reg[IW-1:0];
                        end
                    endcase
                end else begin
                    prev_next = cur_reg;
                    pkey_next = nkey;
                    ppay_next = npay;
                    cur_next  = nlink;
                    if (nlink != cht_pkg::NULL_LINK) begin
                        node_re = 1'b1;
                    end else if (op_reg == cht_pkg::OP_INSERT) begin
                        if (fcnt_reg == '0) begin
                            rst_next = cht_pkg::STAT_FULL;
                        end else begin
                            free_re = 1'b1;
                        end
                    end
                end
            end
            cht_pkg::S_POP_WT: begin
                nidx_next  = pop_idx;
                node_we    = 1'b1;
                node_waddr = pop_idx;
                node_wdata = {key_reg, pay_reg, cht_pkg::NULL_LINK};
                fcnt_next  = fcnt_dec;
                if (fcnt_dec < low_reg) begin
                    low_next = fcnt_dec;
                end
                rst_next  = cht_pkg::STAT_OK;
                rpay_next = pay_reg;
                ridx_next = pop_idx;
                if (prev_reg == cht_pkg::NULL_LINK) begin
                    head_we    = 1'b1;
                    head_wdata = {1'b0, pop_idx};
                end
            end
            cht_pkg::S_LINK_WR: begin
                node_we    = 1'b1;
                node_wdata = {pkey_reg, ppay_reg, {1'b0, nidx_reg}};
            end
            cht_pkg::S_RESP: begin
                if (!mval_reg || m_tready) begin
                    mval_next = 1'b1;
                    mst_next  = rst_reg;
                    mpay_next = rpay_reg;
                    midx_next = ridx_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cht_pkg::S_CLEAR;
            clr_reg    <= '0;
            bcount_reg <= cht_pkg::CFG_W'(cht_pkg::MIN_BUCKETS);
            fcnt_reg   <= LW'(cht_pkg::POOL_NODES);
            low_reg    <= LW'(cht_pkg::POOL_NODES);
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            bcount_reg <= bcount_next;
            fcnt_reg   <= fcnt_next;
            low_reg    <= low_next;
            mval_reg   <= mval_next;
        end
        op_reg   <= op_next;
        key_reg  <= key_next;
        pay_reg  <= pay_next;
        bkt_reg  <= bkt_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        pkey_reg <= pkey_next;
        ppay_reg <= ppay_next;
        nidx_reg <= nidx_next;
        rst_reg  <= rst_next;
        rpay_reg <= rpay_next;
        ridx_reg <= ridx_next;
        mst_reg  <= mst_next;
        mpay_reg <= mpay_next;
        midx_reg <= midx_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = mval_reg;
    assign m_tuser   = mst_reg;
    assign m_tdata   = {6'b0, midx_reg, mpay_reg};

    `CHT_ASSERT(a_fcnt_bound, fcnt_reg <= LW'(cht_pkg::POOL_NODES), "free count overflow")
    `CHT_ASSERT(a_low_water, low_reg <= fcnt_reg, "free low-water above free count")
    `CHT_ASSERT(a_one_in_work, s_acc |=> !s_tready, "second word taken while busy")
    `CHT_ASSERT_ALWAYS(a_clear_after_reset, !aresetn |=> !s_tready, "word taken during clear")
endmodule
